[hdl/spq_pkg.sv]
package spq_pkg;

  // Command codes carried in the low bits of the input beat
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_t;

  // Status codes returned with every result beat
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Per-cycle operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 2;

endpackage

[hdl/spq_cell.sv]
// One slot of the sorted chain. Holds a single entry and on every cycle either
// keeps it, takes the new entry, takes its left neighbor (insert shifts toward
// the tail) or takes its right neighbor (remove shifts toward the head).
module spq_cell #(
  parameter int VALUE_BITS    = 8,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                            clk,
  input  spq_pkg::op_t                    op_i,
  input  logic                            occ_i,
  input  logic        [VALUE_BITS-1:0]    new_value_i,
  input  logic signed [PRIORITY_BITS-1:0] new_prio_i,
  input  logic                            left_mark_i,
  input  logic        [VALUE_BITS-1:0]    left_value_i,
  input  logic signed [PRIORITY_BITS-1:0] left_prio_i,
  input  logic        [VALUE_BITS-1:0]    right_value_i,
  input  logic signed [PRIORITY_BITS-1:0] right_prio_i,
  output logic                            mark_o,
  output logic        [VALUE_BITS-1:0]    value_o,
  output logic signed [PRIORITY_BITS-1:0] prio_o
);

  logic        [VALUE_BITS-1:0]    value_r, value_nxt;
  logic signed [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // Mark: new entry goes at or before this slot (empty slot or prio >= new)
  assign mark_o = !occ_i || (prio_r >= new_prio_i);

  // Next entry selection
  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    case (op_i)
      spq_pkg::OP_INSERT: begin
        if (left_mark_i) begin
          value_nxt = left_value_i;
          prio_nxt  = left_prio_i;
        end else if (mark_o) begin
          value_nxt = new_value_i;
          prio_nxt  = new_prio_i;
        end
      end
      spq_pkg::OP_REMOVE: begin
        value_nxt = right_value_i;
        prio_nxt  = right_prio_i;
      end
      default: begin
        value_nxt = value_r;
        prio_nxt  = prio_r;
      end
    endcase
  end

  // Entry storage, contents are meaningful only below the fill count
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value_o = value_r;
  assign prio_o  = prio_r;

endmodule

[hdl/sorted_priority_queue.sv]
// Bounded priority queue kept sorted in a chain of CAPACITY cells. Each input
// beat carries a command (insert, remove head, peek head), a payload value and
// a signed priority; each accepted beat yields exactly one result beat with the
// head entry (for remove and peek), a status (ok, overflow on insert when full,
// underflow on remove or peek when empty) and the occupancy after the command.
// Smaller priority numbers leave first; among equal priorities the newest
// entry leaves first. The block takes one command per clock while the sink
// keeps up: every cell compares its own priority against the incoming one in
// parallel and shifts one place left or right in the same cycle, so the
// per-beat cost is a single priority compare per cell. Results appear in the cycle
// after acceptance from an output register; a new command is accepted in the
// cycle the waiting result is taken, and the input stalls while a result waits.
// No clearing pass follows reset; the queue is empty at once.
module sorted_priority_queue #(
  parameter int CAPACITY      = 64,
  parameter int VALUE_BITS    = 8,
  parameter int PRIORITY_BITS = 16,
  localparam int CNT_BITS     = $clog2(CAPACITY + 1),
  localparam int IN_USED      = spq_pkg::CMD_BITS + VALUE_BITS + PRIORITY_BITS,
  localparam int IN_W         = ((IN_USED + 7) / 8) * 8,
  localparam int OUT_USED     = VALUE_BITS + PRIORITY_BITS + spq_pkg::STATUS_BITS + CNT_BITS,
  localparam int OUT_W        = ((OUT_USED + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // in_tdata, low bit up: cmd, item_value, item_priority, zero fill
  input  logic [IN_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // out_tdata, low bit up: head_value, head_priority, status, occupancy, zero fill
  output logic [OUT_W-1:0] out_tdata
);

  // Input beat fields
  spq_pkg::cmd_t                   in_cmd;
  logic        [VALUE_BITS-1:0]    in_value;
  logic signed [PRIORITY_BITS-1:0] in_prio;

  assign in_cmd   = spq_pkg::cmd_t'(in_tdata[spq_pkg::CMD_BITS-1:0]);
  assign in_value = in_tdata[spq_pkg::CMD_BITS +: VALUE_BITS];
  assign in_prio  = in_tdata[spq_pkg::CMD_BITS + VALUE_BITS +: PRIORITY_BITS];

  // Control and output registers
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic                in_acc;
  spq_pkg::op_t        op;

  // Cell chain wiring
  logic                            cell_mark  [CAPACITY];
  logic        [VALUE_BITS-1:0]    cell_value [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Command decode, result formation and fill count update
  always_comb begin
    logic        [VALUE_BITS-1:0]    res_value;
    logic signed [PRIORITY_BITS-1:0] res_prio;
    spq_pkg::status_t                res_status;
    res_value  = '0;
    res_prio   = '0;
    res_status = spq_pkg::ST_OK;
    op         = spq_pkg::OP_HOLD;
    count_nxt  = count_r;
    case (in_cmd)
      spq_pkg::CMD_INSERT: begin
        if (count_r == CNT_BITS'(CAPACITY)) begin
          res_status = spq_pkg::ST_OVERFLOW;
        end else begin
          op        = spq_pkg::OP_INSERT;
          count_nxt = count_r + CNT_BITS'(1);
        end
      end
      spq_pkg::CMD_REMOVE, spq_pkg::CMD_PEEK: begin
        if (count_r == '0) begin
          res_status = spq_pkg::ST_UNDERFLOW;
        end else begin
          res_value = cell_value[0];
          res_prio  = cell_prio[0];
          if (in_cmd == spq_pkg::CMD_REMOVE) begin
            op        = spq_pkg::OP_REMOVE;
            count_nxt = count_r - CNT_BITS'(1);
          end
        end
      end
      default: begin
        op = spq_pkg::OP_HOLD;
      end
    endcase
    if (!in_acc) begin
      op        = spq_pkg::OP_HOLD;
      count_nxt = count_r;
    end
    out_data_nxt = OUT_W'({count_nxt, res_status, res_prio, res_value});
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload holds while waiting for the sink
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Chain of cells, index 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                            left_mark;
    logic        [VALUE_BITS-1:0]    left_value, right_value;
    logic signed [PRIORITY_BITS-1:0] left_prio, right_prio;

    if (i == 0) begin : g_head
      assign left_mark  = 1'b0;
      assign left_value = in_value;
      assign left_prio  = in_prio;
    end else begin : g_body
      assign left_mark  = cell_mark[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk           (clk),
      .op_i          (op),
      .occ_i         (count_r > CNT_BITS'(i)),
      .new_value_i   (in_value),
      .new_prio_i    (in_prio),
      .left_mark_i   (left_mark),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .mark_o        (cell_mark[i]),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i])
    );
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("fill count above capacity");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_BITS'(2) |-> cell_prio[0] <= cell_prio[1])
    else $error("head entry out of order");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == spq_pkg::CMD_REMOVE && count_r != '0
    |=> count_r == $past(count_r) - CNT_BITS'(1))
    else $error("remove did not drop one entry");

  a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == spq_pkg::CMD_INSERT && count_r == '0
    |=> cell_prio[0] == $past(in_prio) && cell_value[0] == $past(in_value))
    else $error("insert into empty queue lost entry");

endmodule
